@@ hw/rtl/lgrs_pkg.sv @@
`default_nettype none

package lgrs_pkg;

  // Fixed field widths
  localparam int ROW_W   = 64;
  localparam int INDEX_W = 10;
  localparam int COLS_W  = 7;
  localparam int ROWS_W  = 11;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 2;

  // Hard limit on frame height set by the row index width
  localparam int INDEX_LIMIT = 1 << INDEX_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;

  // Register reset values
  localparam logic [COLS_W-1:0] COLS_RESET = 7'd64;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 11'd1024;

  // One result item
  typedef struct packed {
    logic [ROW_W-1:0]   next_row;
    logic [INDEX_W-1:0] row_index;
    logic               last_row;
  } result_t;

  // Push request into the result queue
  typedef struct packed {
    logic first;
    logic second;
  } push_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/lgrs_evolve.sv @@
`default_nettype none

// One Life generation step for a single row: B3/S23, dead beyond both edges.
module lgrs_evolve (
  input  wire logic [lgrs_pkg::ROW_W-1:0] up,
  input  wire logic [lgrs_pkg::ROW_W-1:0] mid,
  input  wire logic [lgrs_pkg::ROW_W-1:0] down,
  input  wire logic [lgrs_pkg::ROW_W-1:0] mask,
  output logic      [lgrs_pkg::ROW_W-1:0] row
);
  import lgrs_pkg::*;

  logic [ROW_W+1:0] up_pad;
  logic [ROW_W+1:0] mid_pad;
  logic [ROW_W+1:0] down_pad;

  // Masked rows with a dead cell on each side
  assign up_pad   = {1'b0, up & mask, 1'b0};
  assign mid_pad  = {1'b0, mid & mask, 1'b0};
  assign down_pad = {1'b0, down & mask, 1'b0};

  // Per-lane neighbor count and rule
  always_comb begin
    logic [3:0] n;
    for (int i = 0; i < ROW_W; i++) begin
      n = 4'(up_pad[i]) + 4'(up_pad[i+1]) + 4'(up_pad[i+2])
        + 4'(mid_pad[i]) + 4'(mid_pad[i+2])
        + 4'(down_pad[i]) + 4'(down_pad[i+1]) + 4'(down_pad[i+2]);
      row[i] = mask[i] & ((n == 4'd3) | (mid_pad[i+1] & (n == 4'd2)));
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lgrs_result_queue.sv @@
`default_nettype none

// Three-entry result queue: head at slot 0, up to two pushes and one pop per cycle.
module lgrs_result_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lgrs_pkg::push_req_t push,
  input  wire lgrs_pkg::result_t   first_item,
  input  wire lgrs_pkg::result_t   second_item,
  input  wire logic                pop,
  output lgrs_pkg::result_t        head,
  output logic                     not_empty,
  output logic                     has_room
);
  import lgrs_pkg::*;

  localparam int DEPTH = 3;

  result_t    slots [DEPTH];
  result_t    slots_next [DEPTH];
  logic [1:0] count;
  logic [1:0] count_base;
  logic [1:0] count_next;
  logic [1:0] second_slot;

  assign head      = slots[0];
  assign not_empty = (count != 2'd0);
  // Room for two pushes
  assign has_room  = (count <= 2'd1);

  // Shift on pop, then write pushes behind what remains
  always_comb begin
    count_base = count - 2'(pop);
    second_slot = count_base + 2'(push.first);
    for (int i = 0; i < DEPTH; i++) begin
      if (pop && (i < DEPTH - 1)) begin
        slots_next[i] = slots[i+1];
      end else begin
        slots_next[i] = slots[i];
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (push.first && (count_base == 2'(i))) begin
        slots_next[i] = first_item;
      end
      if (push.second && (second_slot == 2'(i))) begin
        slots_next[i] = second_item;
      end
    end
    count_next = count_base + 2'(push.first) + 2'(push.second);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      slots[i] <= slots_next[i];
    end
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/life_generation_row_stream_unit.sv @@
`default_nettype none

// Life generation (B3/S23, bounded, no wrap), streamed one grid row per item.
// Input channel in_valid/in_stall carries row_bits, rows of the current
// generation top to bottom. Output channel out_valid/out_stall carries
// next_row with its row_index and last_row flag, one row behind the input.
// Row 0 of a frame gives no result; rows 1..H-2 give one result (the row
// above); the final row gives two (the row above, then itself, last_row=1),
// or only itself when the grid is a single row.
// Each accepted item is held in the input register; when the queue has room
// its results enter the result queue, whose head drives the outputs.
// Throughput is one item per cycle while the queue has room; the final row
// of a frame yields two results, so the input can stall after it while the
// single result port drains the extra result. When out_stall is held the
// queue fills and in_stall rises; nothing is dropped. Registers columns_in_use
// (index 0) and rows_in_use (index 1) are written through cfg_write/cfg_index/
// cfg_data; the user must do so only while the block is idle, which the
// block does not enforce. Reset (rst, synchronous) empties the pipeline,
// clears stored rows and the row counter, and sets width 64, height 1024.
module life_generation_row_stream_unit #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [lgrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lgrs_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [lgrs_pkg::ROW_W-1:0]      row_bits,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [lgrs_pkg::ROW_W-1:0]      next_row,
  output logic      [lgrs_pkg::INDEX_W-1:0]    row_index,
  output logic                                 last_row
);
  import lgrs_pkg::*;

  localparam int ROW_LIMIT = (MAX_ROWS > INDEX_LIMIT) ? INDEX_LIMIT : MAX_ROWS;

  logic [COLS_W-1:0]  columns_in_use;
  logic [ROWS_W-1:0]  rows_in_use;
  logic [ROW_W-1:0]   upper_row;
  logic [ROW_W-1:0]   middle_row;
  logic [INDEX_W-1:0] row_counter;

  logic               stage_valid;
  logic [ROW_W-1:0]   stage_row;

  logic [COLS_W-1:0]  cols_eff;
  logic [ROWS_W-1:0]  height;
  logic [ROW_W-1:0]   mask;
  logic [ROW_W-1:0]   cur;
  logic [ROW_W-1:0]   above;
  logic [ROW_W-1:0]   row_a;
  logic [ROW_W-1:0]   row_b;
  logic               not_top;
  logic               frame_end;
  logic               advance;
  logic               accept;
  logic               q_room;
  logic               q_pop;
  push_req_t          push;
  result_t            res_a;
  result_t            res_b;
  result_t            first_item;
  result_t            q_head;

  // Effective width and height
  always_comb begin
    if (columns_in_use == '0) begin
      cols_eff = COLS_W'(1);
    end else if (columns_in_use > COLS_W'(MAX_COLUMNS)) begin
      cols_eff = COLS_W'(MAX_COLUMNS);
    end else begin
      cols_eff = columns_in_use;
    end
    if (rows_in_use == '0) begin
      height = ROWS_W'(1);
    end else if (rows_in_use > ROWS_W'(ROW_LIMIT)) begin
      height = ROWS_W'(ROW_LIMIT);
    end else begin
      height = rows_in_use;
    end
    for (int i = 0; i < ROW_W; i++) begin
      mask[i] = (COLS_W'(i) < cols_eff);
    end
  end

  // Row position within the frame
  assign cur       = stage_row & mask;
  assign not_top   = (row_counter != '0);
  assign frame_end = (ROWS_W'(row_counter) + ROWS_W'(1)) >= height;
  assign above     = not_top ? middle_row : '0;

  lgrs_evolve u_evolve_above (
    .up   (upper_row),
    .mid  (middle_row),
    .down (cur),
    .mask (mask),
    .row  (row_a)
  );

  lgrs_evolve u_evolve_last (
    .up   (above),
    .mid  (cur),
    .down ('0),
    .mask (mask),
    .row  (row_b)
  );

  // Results of the staged item
  always_comb begin
    res_a.next_row  = row_a;
    res_a.row_index = row_counter - INDEX_W'(1);
    res_a.last_row  = 1'b0;
    res_b.next_row  = row_b;
    res_b.row_index = row_counter;
    res_b.last_row  = 1'b1;
    first_item      = not_top ? res_a : res_b;
    push.first      = advance & (not_top | frame_end);
    push.second     = advance & not_top & frame_end;
  end

  // Handshakes
  assign advance  = stage_valid & q_room;
  assign in_stall = stage_valid & ~q_room;
  assign accept   = in_valid & ~in_stall;
  assign q_pop    = out_valid & ~out_stall;

  lgrs_result_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .first_item  (first_item),
    .second_item (res_b),
    .pop         (q_pop),
    .head        (q_head),
    .not_empty   (out_valid),
    .has_room    (q_room)
  );

  assign next_row  = q_head.next_row;
  assign row_index = q_head.row_index;
  assign last_row  = q_head.last_row;

  // Input register
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_row <= row_bits;
    end
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  // Row history and frame counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_row   <= '0;
      middle_row  <= '0;
      row_counter <= '0;
    end else if (advance) begin
      if (frame_end) begin
        upper_row   <= '0;
        middle_row  <= '0;
        row_counter <= '0;
      end else begin
        upper_row   <= above;
        middle_row  <= cur;
        row_counter <= row_counter + INDEX_W'(1);
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= COLS_RESET;
      rows_in_use    <= ROWS_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_COLUMNS) begin
        columns_in_use <= cfg_data[COLS_W-1:0];
      end else if (cfg_index == CFG_ROWS) begin
        rows_in_use <= cfg_data[ROWS_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

@@ sim/life_generation_row_stream_unit_tb.sv @@
`default_nettype none

module life_generation_row_stream_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lgrs_pkg::*;

  localparam int MAX_COLS = 64;
  localparam int TB_MAX_ROWS = 1024;
  localparam int DRAIN_TAIL = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX = 10;

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

  localparam logic [ROW_W-1:0] ALL_ALIVE = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [ROW_W-1:0] ALL_DEAD = 64'h0;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [ROW_W-1:0] row_bits;
  logic out_valid;
  logic out_stall;
  logic [ROW_W-1:0] next_row;
  logic [INDEX_W-1:0] row_index;
  logic last_row;

  life_generation_row_stream_unit #(
    .MAX_COLUMNS(MAX_COLS),
    .MAX_ROWS(TB_MAX_ROWS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .row_bits(row_bits),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .next_row(next_row),
    .row_index(row_index),
    .last_row(last_row)
  );

  // Shadow copy of the grid state and registers
  logic [COLS_W-1:0] cols_reg;
  logic [ROWS_W-1:0] rows_reg;
  logic [ROW_W-1:0] upper_row;
  logic [ROW_W-1:0] middle_row;
  int row_pos;

  result_t pending_rows[$];
  int fail_count = 0;
  int cycle_count = 0;
  int send_gap_pct = 14;
  int recv_stall_pct = 70;

  // Directed stimulus: a row item or a register write; single-row grid
  // outputs are typed in, the rest come from the shadow grid
  typedef enum logic {STEP_ROW, STEP_CFG} plan_op_t;

  typedef struct packed {
    plan_op_t op;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0] reg_data;
    logic [ROW_W-1:0] cells;
    logic typed;
    logic [ROW_W-1:0] want_row;
    logic [INDEX_W-1:0] want_index;
    logic want_last;
  } plan_step_t;

  localparam int PLAN_LEN = 25;

  plan_step_t plan [PLAN_LEN] = '{
    // default 64 x 1024 grid after reset
    '{STEP_ROW, CFG_COLUMNS, 11'd0, ALL_ALIVE, 1'b0, ALL_DEAD, 10'd0, 1'b0},
    '{STEP_ROW, CFG_COLUMNS, 11'd0, ALL_DEAD, 1'b0, ALL_DEAD, 10'd0, 1'b0},
    // height cut below the current row: next row closes the frame
    '{STEP_CFG, CFG_ROWS, 11'd1, ALL_DEAD, 1'b0, ALL_DEAD, 10'd0, 1'b0},
    '{STEP_ROW, CFG_COLUMNS, 11'd0, 64'h8000_0000_0000_0001, 1'b0, ALL_DEAD, 10'd0, 1'b0},
    // single-row grid: both ends die, interior survives on two neighbors
    '{STEP_ROW, CFG_COLUMNS, 11'd0, ALL_ALIVE, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE, 10'd0, 1'b1},
    '{STEP_ROW, CFG_COLUMNS, 11'd0, ALL_DEAD, 1'b1, ALL_DEAD, 10'd0, 1'b1},
    // zero width acts as one column: lone cell dies
    '{STEP_CFG, CFG_COLUMNS, 11'd0, ALL_DEAD, 1'b0, ALL_DEAD, 10'd0, 1'b0},
    '{STEP_ROW, CFG_COLUMNS, 11'd0, ALL_ALIVE, 1'b1, ALL_DEAD, 10'd0, 1'b1},
    // oversized width clamps to full
    '{STEP_CFG, CFG_COLUMNS, 11'h7FF, ALL_DEAD, 1'b0, ALL_DEAD, 10'd0, 1'b0},
    '{STEP_ROW, CFG_COLUMNS, 11'd0, 64'h7, 1'b1, 64'h2, 10'd0, 1'b1},
    // undecoded indexes leave both registers alone
    '{STEP_CFG, CFG_UNUSED_2, 11'd1, ALL_DEAD, 1'b0, ALL_DEAD, 10'd0, 1'b0},
    '{STEP_CFG, CFG_UNUSED_3, 11'd3, ALL_DEAD, 1'b0, ALL_DEAD, 10'd0, 1'b0},
    '{STEP_ROW, CFG_COLUMNS, 11'd0, 64'h7, 1'b1, 64'h2, 10'd0, 1'b1},
    // zero height acts as one row; top columns
    '{STEP_CFG, CFG_ROWS, 11'd0, ALL_DEAD, 1'b0, ALL_DEAD, 10'd0, 1'b0},
    '{STEP_ROW, CFG_COLUMNS, 11'd0, 64'hE000_0000_0000_0000, 1'b1,
      64'h4000_0000_0000_0000, 10'd0, 1'b1},
    // 5 x 3 blinker with garbage above the width
    '{STEP_CFG, CFG_ROWS, 11'd3, ALL_DEAD, 1'b0, ALL_DEAD, 10'd0, 1'b0},
    '{STEP_CFG, CFG_COLUMNS, 11'd5, ALL_DEAD, 1'b0, ALL_DEAD, 10'd0, 1'b0},
    '{STEP_ROW, CFG_COLUMNS, 11'd0, 64'hFFFF_FFFF_FFFF_FFE2, 1'b0, ALL_DEAD, 10'd0, 1'b0},
    '{STEP_ROW, CFG_COLUMNS, 11'd0, 64'h2, 1'b0, ALL_DEAD, 10'd0, 1'b0},
    '{STEP_ROW, CFG_COLUMNS, 11'd0, 64'hA5A5_A5A5_A5A5_A5A2, 1'b0, ALL_DEAD, 10'd0, 1'b0},
    // width narrowed mid-frame also masks the stored rows
    '{STEP_CFG, CFG_COLUMNS, 11'd64, ALL_DEAD, 1'b0, ALL_DEAD, 10'd0, 1'b0},
    '{STEP_ROW, CFG_COLUMNS, 11'd0, ALL_ALIVE, 1'b0, ALL_DEAD, 10'd0, 1'b0},
    '{STEP_ROW, CFG_COLUMNS, 11'd0, ALL_ALIVE, 1'b0, ALL_DEAD, 10'd0, 1'b0},
    '{STEP_CFG, CFG_COLUMNS, 11'd3, ALL_DEAD, 1'b0, ALL_DEAD, 10'd0, 1'b0},
    '{STEP_ROW, CFG_COLUMNS, 11'd0, ALL_ALIVE, 1'b0, ALL_DEAD, 10'd0, 1'b0}
  };

  // B3/S23 on one row with its neighbors above and below
  function automatic logic [ROW_W-1:0] life_rule(input logic [ROW_W-1:0] up,
                                                 input logic [ROW_W-1:0] mid,
                                                 input logic [ROW_W-1:0] dn,
                                                 input logic [ROW_W-1:0] mask);
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    logic [ROW_W-1:0] c;
    logic [ROW_W-1:0] nxt;
    int n;
    a = up & mask;
    b = mid & mask;
    c = dn & mask;
    nxt = '0;
    for (int i = 0; i < ROW_W; i++) begin
      n = int'(a[i]) + int'(c[i]);
      if (i > 0) n += int'(a[i-1]) + int'(b[i-1]) + int'(c[i-1]);
      if (i < ROW_W - 1) n += int'(a[i+1]) + int'(b[i+1]) + int'(c[i+1]);
      nxt[i] = (n == 3) || (b[i] && n == 2);
    end
    return nxt & mask;
  endfunction

  function automatic int grid_height();
    int h;
    h = rows_reg;
    if (h < 1) h = 1;
    if (h > TB_MAX_ROWS) h = TB_MAX_ROWS;
    if (h > INDEX_LIMIT) h = INDEX_LIMIT;
    return h;
  endfunction

  // Mix of sparse, dense and even row patterns
  function automatic logic [ROW_W-1:0] random_cells();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return a & b;
      1: return a | b;
      2: return a & b & {$urandom, $urandom};
      default: return a;
    endcase
  endfunction

  // Shadow grid update for one accepted row; keep queues its results
  task automatic advance_grid(input logic [ROW_W-1:0] cells, input bit keep);
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] cur;
    logic [ROW_W-1:0] above;
    int c;
    int k;
    bit closes;
    result_t r;
    c = cols_reg;
    if (c < 1) c = 1;
    if (c > MAX_COLS) c = MAX_COLS;
    mask = (c == ROW_W) ? '1 : ((ROW_W'(1) << c) - 1);
    cur = cells & mask;
    k = row_pos;
    closes = (k + 1 >= grid_height());
    if (k > 0 && keep) begin
      r.next_row = life_rule(upper_row, middle_row, cur, mask);
      r.row_index = INDEX_W'(k - 1);
      r.last_row = 1'b0;
      pending_rows.push_back(r);
    end
    if (closes) begin
      above = (k > 0) ? middle_row : '0;
      if (keep) begin
        r.next_row = life_rule(above, cur, '0, mask);
        r.row_index = INDEX_W'(k);
        r.last_row = 1'b1;
        pending_rows.push_back(r);
      end
      upper_row = '0;
      middle_row = '0;
      row_pos = 0;
    end else begin
      upper_row = (k > 0) ? middle_row : '0;
      middle_row = cur;
      row_pos = k + 1;
    end
  endtask

  // Offer one row item, with random gaps ahead of it
  task automatic send_row(input logic [ROW_W-1:0] cells, input bit keep);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    row_bits <= cells;
    do @(posedge clk); while (in_stall);
    advance_grid(cells, keep);
  endtask

  // Hold the sender off until every expected row is out, plus a tail
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == CFG_COLUMNS) cols_reg = value[COLS_W-1:0];
    else if (idx == CFG_ROWS) rows_reg = value[ROWS_W-1:0];
  endtask

  // Random bursts of rows between random register settings
  task automatic run_random_phase(input int item_goal);
    int sent;
    int burst;
    logic [CFG_W-1:0] value;
    sent = 0;
    while (sent < item_goal) begin
      wait_drained();
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 9) < 7)
          value = {4'($urandom_range(0, 15)), 7'($urandom_range(1, 64))};
        else
          value = CFG_W'($urandom);
        write_register(CFG_COLUMNS, value);
      end
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 9) < 8) value = CFG_W'($urandom_range(0, 10));
        else value = CFG_W'($urandom_range(11, 48));
        write_register(CFG_ROWS, value);
      end
      if ($urandom_range(0, 9) == 0)
        write_register($urandom_range(0, 1) ? CFG_UNUSED_2 : CFG_UNUSED_3, CFG_W'($urandom));
      burst = $urandom_range(1, 3 * grid_height() + 2);
      repeat (burst) send_row(random_cells(), 1'b1);
      sent += burst;
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: check each accepted item, then pick the next stall
  initial begin
    result_t want;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_rows.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected row: got %h idx %0d last %0d", next_row, row_index, last_row);
        end else begin
          want = pending_rows.pop_front();
          if (next_row !== want.next_row || row_index !== want.row_index ||
              last_row !== want.last_row) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("row mismatch: want %h idx %0d last %0d, got %h idx %0d last %0d",
                       want.next_row, want.row_index, want.last_row,
                       next_row, row_index, last_row);
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Stimulus
  initial begin
    result_t typed_row;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= CFG_COLUMNS;
    cfg_data <= '0;
    in_valid <= 1'b0;
    row_bits <= '0;
    cols_reg = COLS_RESET;
    rows_reg = ROWS_RESET;
    upper_row = '0;
    middle_row = '0;
    row_pos = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; sender with occasional gaps, receiver mostly stalled
    foreach (plan[s]) begin
      if (plan[s].op == STEP_CFG) begin
        wait_drained();
        write_register(plan[s].reg_index, plan[s].reg_data);
      end else begin
        send_row(plan[s].cells, !plan[s].typed);
        if (plan[s].typed) begin
          typed_row.next_row = plan[s].want_row;
          typed_row.row_index = plan[s].want_index;
          typed_row.last_row = plan[s].want_last;
          pending_rows.push_back(typed_row);
        end
      end
    end
    run_random_phase(110);

    // sender mostly idle, receiver rarely stalls
    wait_drained();
    send_gap_pct = 70;
    recv_stall_pct = 14;
    run_random_phase(110);

    // back to back on both sides
    wait_drained();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    run_random_phase(120);

    // one frame at the height limit, out to the top row index
    wait_drained();
    write_register(CFG_ROWS, CFG_W'($urandom_range(1024, 2047)));
    write_register(CFG_COLUMNS, CFG_W'($urandom));
    repeat (INDEX_LIMIT - row_pos) send_row(random_cells(), 1'b1);
    wait_drained();

    if (fail_count == 0 && pending_rows.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ life_generation_row_stream_unit.f @@
hw/rtl/lgrs_pkg.sv
hw/rtl/lgrs_evolve.sv
hw/rtl/lgrs_result_queue.sv
hw/rtl/life_generation_row_stream_unit.sv
sim/life_generation_row_stream_unit_tb.sv
